/* hdl/murmur3_32_stream_hash_core_defines.svh */
// ----------------------------------------------------------------------------
// MurmurHash3 stream core assertion macros
// Shared assertion forms for the hash core. They use the clk and arst_n names
// of the module in which they stand.
// ----------------------------------------------------------------------------
`ifndef MURMUR3_32_STREAM_HASH_CORE_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MM3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mm3_pkg.sv */
// ----------------------------------------------------------------------------
// MurmurHash3 stream core package
// Constants, multiplier operand codes and register map of the hash core.
// ----------------------------------------------------------------------------
package mm3_pkg;

	// Mixing constants of MurmurHash3 x86_32.
	localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2 = 32'h1b873593;
	localparam logic [31:0] MIX_N  = 32'he6546b64;
	localparam logic [31:0] FMIX_1 = 32'h85ebca6b;
	localparam logic [31:0] FMIX_2 = 32'hc2b2ae35;
	localparam logic [31:0] MIX_M  = 32'd5;

	// Constant operand select of the shared multiplier.
	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MUL_C1 = 3'd0;
	localparam mul_sel_t MUL_C2 = 3'd1;
	localparam mul_sel_t MUL_M  = 3'd2;
	localparam mul_sel_t MUL_F1 = 3'd3;
	localparam mul_sel_t MUL_F2 = 3'd4;

	// Register map: the register index is the word address.
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_SEED = 1'b0;

	// Constant operand for a select code.
	function automatic logic [31:0] mul_const(input mul_sel_t sel);
		logic [31:0] c;
		case (sel)
			MUL_C1: c = MIX_C1;
			MUL_C2: c = MIX_C2;
			MUL_M: c = MIX_M;
			MUL_F1: c = FMIX_1;
			MUL_F2: c = FMIX_2;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* hdl/mm3_mul.sv */
// ----------------------------------------------------------------------------
// MurmurHash3 shared multiplier
// Registered 32 x 32 multiplier that keeps the low 32 bits of the product;
// the second operand is one of the hash constants.
// ----------------------------------------------------------------------------
module mm3_mul (
	input  logic             clk,
	input  logic             en,
	input  logic [31:0]      a,
	input  mm3_pkg::mul_sel_t sel,
	output logic [31:0]      prod
);

	logic [31:0] prod_q;
	logic [63:0] full;

	// Full product; only the low word is kept.
	assign full = 64'(a) * 64'(mm3_pkg::mul_const(sel));

	// The product register holds its value while the unit is not in use.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= full[31:0];
		end
	end

	assign prod = prod_q;

endmodule

/* hdl/murmur3_32_stream_hash_core.sv */
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 stream hash core: a byte that does not end a block never stalls.
// A byte that ends a block stalls for 3 multiplier passes and a hash update.
// A last beat stalls through any block or tail mix, finalization and held-result wait.
// Reset clears the seed to zero and the hash state to that seed; outputs are empty.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mm3_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// Byte input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  byte_value,
	input  logic                        is_last,
	input  logic                        no_byte,
	// Hash output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [31:0]                 hash_value,
	output logic [31:0]                 string_length
);

	// Sequencer state codes.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_BK1  = 4'd1;
	localparam logic [3:0] ST_BK2  = 4'd2;
	localparam logic [3:0] ST_BH1  = 4'd3;
	localparam logic [3:0] ST_BH2  = 4'd4;
	localparam logic [3:0] ST_TK1  = 4'd5;
	localparam logic [3:0] ST_TK2  = 4'd6;
	localparam logic [3:0] ST_FM1  = 4'd7;
	localparam logic [3:0] ST_FM2  = 4'd8;
	localparam logic [3:0] ST_FM3  = 4'd9;

	logic [3:0]  state_q;
	logic [31:0] seed_q;
	logic [31:0] hash_q;
	logic [31:0] pend_q;
	logic [1:0]  phase_q;
	logic [31:0] count_q;
	logic        busy_q;
	logic        last_q;
	logic        tail_q;
	logic        out_valid_q;
	logic [31:0] hash_out_q;
	logic [31:0] len_out_q;

	logic        in_beat;
	logic        cfg_wr;
	logic        out_load;
	logic        mul_en;
	logic [31:0] mul_a;
	mm3_pkg::mul_sel_t mul_sel;
	logic [31:0] prod;
	logic [31:0] fin_t;
	logic [31:0] fin_out;

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] x);
		return {x[18:0], x[31:19]};
	endfunction

	// Handshakes.
	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == mm3_pkg::REG_SEED);
	assign out_load = (state_q == ST_FM3) && (!out_valid_q || !out_stall);

	// Configuration read-back.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == mm3_pkg::REG_SEED) ? seed_q : '0;

	// Operand selection for the shared multiplier.
	assign fin_t   = hash_q ^ (tail_q ? prod : '0) ^ count_q;
	assign fin_out = prod ^ {16'd0, prod[31:16]};

	always_comb begin
		mul_en  = 1'b1;
		mul_a   = '0;
		mul_sel = mm3_pkg::MUL_C1;
		case (state_q)
			ST_BK1, ST_TK1: begin
				mul_a   = pend_q;
				mul_sel = mm3_pkg::MUL_C1;
			end
			ST_BK2, ST_TK2: begin
				mul_a   = rotl15(prod);
				mul_sel = mm3_pkg::MUL_C2;
			end
			ST_BH1: begin
				mul_a   = rotl13(hash_q ^ prod);
				mul_sel = mm3_pkg::MUL_M;
			end
			ST_FM1: begin
				mul_a   = fin_t ^ {16'd0, fin_t[31:16]};
				mul_sel = mm3_pkg::MUL_F1;
			end
			ST_FM2: begin
				mul_a   = prod ^ {13'd0, prod[31:13]};
				mul_sel = mm3_pkg::MUL_F2;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	mm3_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.sel  (mul_sel),
		.prod (prod)
	);

	// Sequencer and hash state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_q  <= '0;
			hash_q  <= '0;
			pend_q  <= '0;
			phase_q <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			last_q  <= 1'b0;
			tail_q  <= 1'b0;
		end else begin
			// A seed write reloads the hash only between strings.
			if (cfg_wr) begin
				seed_q <= pwdata;
				if (!busy_q) begin
					hash_q <= pwdata;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						last_q <= is_last;
						if (!no_byte) begin
							busy_q  <= 1'b1;
							count_q <= count_q + 32'd1;
							phase_q <= phase_q + 2'd1;
							case (phase_q)
								2'd0: pend_q[7:0] <= byte_value;
								2'd1: pend_q[15:8] <= byte_value;
								2'd2: pend_q[23:16] <= byte_value;
								default: pend_q[31:24] <= byte_value;
							endcase
							if (phase_q == 2'd3) begin
								state_q <= ST_BK1;
							end else if (is_last) begin
								tail_q  <= 1'b1;
								state_q <= ST_TK1;
							end
						end else if (is_last) begin
							if (phase_q != 2'd0) begin
								tail_q  <= 1'b1;
								state_q <= ST_TK1;
							end else begin
								state_q <= ST_FM1;
							end
						end
					end
				end
				ST_BK1: begin
					pend_q  <= '0;
					state_q <= ST_BK2;
				end
				ST_BK2: begin
					state_q <= ST_BH1;
				end
				ST_BH1: begin
					state_q <= ST_BH2;
				end
				ST_BH2: begin
					hash_q  <= prod + mm3_pkg::MIX_N;
					state_q <= last_q ? ST_FM1 : ST_IDLE;
				end
				ST_TK1: begin
					state_q <= ST_TK2;
				end
				ST_TK2: begin
					state_q <= ST_FM1;
				end
				ST_FM1: begin
					state_q <= ST_FM2;
				end
				ST_FM2: begin
					state_q <= ST_FM3;
				end
				ST_FM3: begin
					// Restart from the seed once the result is in the output register.
					if (out_load) begin
						hash_q  <= seed_q;
						pend_q  <= '0;
						phase_q <= '0;
						count_q <= '0;
						busy_q  <= 1'b0;
						last_q  <= 1'b0;
						tail_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hash_out_q <= fin_out;
			len_out_q  <= count_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hash_value    = hash_out_q;
	assign string_length = len_out_q;

	// Assertions.
	`include "murmur3_32_stream_hash_core_defines.svh"

	`MM3_ASSERT_NEXT(a_block_starts_mix, in_beat && !no_byte && (phase_q == 2'd3),
		state_q == ST_BK1, "block byte did not start the mix")
	`MM3_ASSERT_NEXT(a_plain_byte_counts,
		in_beat && !no_byte && !is_last && (phase_q != 2'd3),
		(state_q == ST_IDLE) && (count_q == $past(count_q) + 32'd1),
		"plain byte not absorbed")
	`MM3_ASSERT_NEXT(a_result_restarts, out_load,
		out_valid_q && (count_q == 32'd0) && !busy_q && (state_q == ST_IDLE),
		"no restart after result")
	`MM3_ASSERT_NOW(a_tail_has_bytes, tail_q, phase_q != 2'd0, "tail mix without pending bytes")

endmodule
